// File: src/wfsa_pkg.sv
// ---------------------------------------------------------------------------
// wfsa_pkg: shared types and constants of the worst-fit segment allocator
// Request kinds, status codes, sequencer states and default sizes.
// ---------------------------------------------------------------------------
package wfsa_pkg;

	localparam int MEM_UNITS_DEF    = 1024;
	localparam int MAX_SEG_DEF      = 64;
	localparam int OWNER_BITS_DEF   = 16;

	localparam int ID_W    = 16;
	localparam int SIZE_W  = 11;
	localparam int START_W = 10;
	localparam int STAT_W  = 2;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_ID    = 2'd1,
		ST_NOFIT = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	localparam logic REQ_ALLOC   = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	typedef enum logic [3:0] {
		S_INIT,    // write entry 0 after reset or size write
		S_IDLE,
		S_SCAN,    // walk entries, one read per cycle
		S_DECIDE,
		S_SHIFT,   // move entries one place, one at a time, read then write
		S_FIX,     // patch entries around the pick
		S_RESP
	} fsm_t;

endpackage

// File: src/worst_fit_segment_allocator.sv
// ---------------------------------------------------------------------------
// worst_fit_segment_allocator: address-ordered segment table, worst fit
// Allocates and releases contiguous unit ranges owned by ids.
// ---------------------------------------------------------------------------
// Steps: accept, scan of the table, decide, a read and a write per entry moved
// on a split or merge (a release merges before it moves), up to three fixup
// writes, response.
// Throughput: one request at a time; the next word waits for the response.
// Reset: arst_n clears control and enters S_INIT, which rewrites entry 0 (count 1).
module worst_fit_segment_allocator #(
	parameter int MEM_UNITS    = wfsa_pkg::MEM_UNITS_DEF,
	parameter int MAX_SEGMENTS = wfsa_pkg::MAX_SEG_DEF,
	parameter int OWNER_BITS   = wfsa_pkg::OWNER_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: total_units
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data,
	// request words
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] owner_id, [26:16] alloc_size, pad
	input  logic        s_tuser,   // req_type
	// response words
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // [1:0] status, [11:2] block_start,
	                               // [22:12] block_size, pad
);

	localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);

	// packed entry: {owner, used, length, start}
	typedef struct packed {
		logic [OWNER_BITS-1:0]        owner;
		logic                         used;
		logic [wfsa_pkg::SIZE_W-1:0]  len;
		logic [wfsa_pkg::START_W-1:0] start;
	} ent_t;

	ent_t mem [MAX_SEGMENTS];
	ent_t rd_q;

	wfsa_pkg::fsm_t st_q, st_d;

	logic [10:0] tot_q;
	logic [CW-1:0] cnt_q;
	logic          kind_q;
	logic [OWNER_BITS-1:0] id_q;
	logic [10:0] size_q;

	// scan results
	logic [CW-1:0] ptr_q;          // entry whose read is in flight
	logic          rdv_q;          // rd_q holds entry ptr_q-1
	logic          own_hit_q;
	logic [IW-1:0] own_idx_q;
	logic          fit_q;
	logic [IW-1:0] pick_q;
	ent_t          pick_ent_q;
	ent_t          prev_q;         // entry before the one in rd_q
	ent_t          own_prev_q, own_ent_q, own_next_q;
	logic          own_next_v_q;
	logic          grab_next_q;

	// shift/fix sequencer
	logic [CW-1:0] sh_q;           // current shift position
	logic          sh_up_q;        // 1 insert (move up), 0 remove (move down)
	logic [CW-1:0] sh_end_q;
	logic          sh_ph_q;        // 0 read, 1 write
	logic [1:0]    fix_q;          // fix step counter
	logic [CW-1:0] rm_q;           // further entries to remove on release

	logic [1:0]  stat_q;
	logic [9:0]  bst_q;
	logic [10:0] bsz_q;
	logic        mval_q;

	// memory port
	logic          we, re;
	logic [IW-1:0] wa, ra;
	ent_t          wd;

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (re) rd_q <= mem[ra];
	end

	logic [CW-1:0] scan_idx;
	assign scan_idx = ptr_q - CW'(1);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			wfsa_pkg::S_INIT: st_d = wfsa_pkg::S_IDLE;
			wfsa_pkg::S_IDLE: if (s_tvalid && s_tready) st_d = wfsa_pkg::S_SCAN;
			wfsa_pkg::S_SCAN: if (rdv_q && ptr_q == cnt_q) st_d = wfsa_pkg::S_DECIDE;
			wfsa_pkg::S_DECIDE: begin
				st_d = wfsa_pkg::S_RESP;
				if (kind_q == wfsa_pkg::REQ_ALLOC) begin
					if (!own_hit_q && size_q != '0 && fit_q) begin
						if (pick_ent_q.len == size_q) st_d = wfsa_pkg::S_FIX;
						else if (cnt_q < CW'(MAX_SEGMENTS)) st_d = wfsa_pkg::S_SHIFT;
					end
				end else if (own_hit_q) begin
					st_d = wfsa_pkg::S_FIX;
				end
			end
			wfsa_pkg::S_SHIFT: if (sh_q == sh_end_q && sh_ph_q) st_d = wfsa_pkg::S_FIX;
			wfsa_pkg::S_FIX: if (fix_q == 2'd0) st_d = wfsa_pkg::S_RESP;
			wfsa_pkg::S_RESP: if (!mval_q || m_tready) st_d = wfsa_pkg::S_IDLE;
			default: st_d = wfsa_pkg::S_IDLE;
		endcase
		if (st_q == wfsa_pkg::S_SHIFT && sh_q == sh_end_q && sh_ph_q && rm_q != '0)
			st_d = wfsa_pkg::S_SHIFT; // second removal on a double merge
	end

	// memory access (outputs)
	always_comb begin
		we = 1'b0; re = 1'b0; wa = '0; ra = '0; wd = '0;
		unique case (st_q)
			wfsa_pkg::S_INIT: begin
				we = 1'b1;
				wd.len = tot_q;
			end
			wfsa_pkg::S_SCAN: begin
				re = (ptr_q < cnt_q);
				ra = ptr_q[IW-1:0];
			end
			wfsa_pkg::S_SHIFT: begin
				// insert: move sh_q-1 -> sh_q ; remove: move sh_q+1 -> sh_q
				if (!sh_ph_q) begin
					re = 1'b1;
					ra = sh_up_q ? IW'(sh_q - CW'(1)) : IW'(sh_q + CW'(1));
				end else begin
					we = 1'b1;
					wa = sh_q[IW-1:0];
					wd = rd_q;
				end
			end
			wfsa_pkg::S_FIX: begin
				we = 1'b1;
				if (kind_q == wfsa_pkg::REQ_ALLOC) begin
					if (pick_ent_q.len == size_q) begin
						wa = pick_q;
						wd = pick_ent_q; wd.used = 1'b1; wd.owner = id_q;
					end else if (fix_q == 2'd2) begin
						wa = pick_q;
						wd.start = pick_ent_q.start; wd.len = size_q;
						wd.used = 1'b1; wd.owner = id_q;
					end else begin
						wa = IW'(pick_q + IW'(1));
						wd.start = pick_ent_q.start + size_q[9:0];
						wd.len = pick_ent_q.len - size_q;
					end
				end else begin
					// merged free entry lands at the lowest index of the run
					wa = (own_idx_q != '0 && !own_prev_q.used) ? own_idx_q - IW'(1)
					                                              : own_idx_q;
					wd.start = (own_idx_q != '0 && !own_prev_q.used)
					           ? own_prev_q.start : own_ent_q.start;
					wd.len = own_ent_q.len
					       + ((own_next_v_q && !own_next_q.used) ? own_next_q.len : '0)
					       + ((own_idx_q != '0 && !own_prev_q.used) ? own_prev_q.len : '0);
				end
			end
			default: ;
		endcase
	end

	// number of entries removed by a release merge
	logic [1:0] merges;
	assign merges = 2'((own_next_v_q && !own_next_q.used) ? 1 : 0)
	              + 2'((own_idx_q != '0 && !own_prev_q.used) ? 1 : 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= wfsa_pkg::S_INIT;
			tot_q  <= 11'(MEM_UNITS);
			cnt_q  <= CW'(1);
			mval_q <= 1'b0;
			ptr_q  <= '0;
			rdv_q  <= 1'b0;
			sh_ph_q <= 1'b0;
			fix_q  <= '0;
			rm_q   <= '0;
		end else begin
			st_q <= st_d;
			if (m_tvalid && m_tready) mval_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				// clamp to 1..MEM_UNITS
				tot_q <= (cfg_data == '0) ? 11'd1
				       : (32'(cfg_data) > MEM_UNITS) ? 11'(MEM_UNITS) : cfg_data;
				st_q  <= wfsa_pkg::S_INIT;
			end
			unique case (st_q)
				wfsa_pkg::S_INIT: cnt_q <= CW'(1);
				wfsa_pkg::S_IDLE: begin
					ptr_q <= '0; rdv_q <= 1'b0;
					own_hit_q <= 1'b0; fit_q <= 1'b0; grab_next_q <= 1'b0;
					own_next_v_q <= 1'b0;
					if (s_tvalid && s_tready) begin
						kind_q <= s_tuser;
						id_q   <= s_tdata[OWNER_BITS-1:0];
						size_q <= s_tdata[26:16];
					end
				end
				wfsa_pkg::S_SCAN: begin
					if (ptr_q < cnt_q) ptr_q <= ptr_q + CW'(1);
					rdv_q <= (ptr_q < cnt_q);
					if (rdv_q) begin
						prev_q <= rd_q;
						if (grab_next_q) begin
							own_next_q <= rd_q; own_next_v_q <= 1'b1;
							grab_next_q <= 1'b0;
						end
						if (!own_hit_q && rd_q.used && rd_q.owner == id_q) begin
							own_hit_q  <= 1'b1;
							own_idx_q  <= scan_idx[IW-1:0];
							own_ent_q  <= rd_q;
							own_prev_q <= prev_q;
							grab_next_q <= 1'b1;
						end
						if (!rd_q.used && rd_q.len >= size_q
						    && (!fit_q || rd_q.len > pick_ent_q.len)) begin
							fit_q <= 1'b1;
							pick_q <= scan_idx[IW-1:0];
							pick_ent_q <= rd_q;
						end
					end
				end
				wfsa_pkg::S_DECIDE: begin
					stat_q <= wfsa_pkg::ST_OK;
					bst_q <= '0; bsz_q <= '0;
					fix_q <= 2'd0; sh_ph_q <= 1'b0;
					if (kind_q == wfsa_pkg::REQ_ALLOC) begin
						if (own_hit_q) stat_q <= wfsa_pkg::ST_ID;
						else if (size_q == '0 || !fit_q) stat_q <= wfsa_pkg::ST_NOFIT;
						else if (pick_ent_q.len != size_q
						         && cnt_q >= CW'(MAX_SEGMENTS)) stat_q <= wfsa_pkg::ST_FULL;
						else begin
							bst_q <= pick_ent_q.start; bsz_q <= size_q;
							if (pick_ent_q.len != size_q) begin
								sh_up_q <= 1'b1; sh_q <= cnt_q;
								sh_end_q <= CW'(pick_q) + CW'(1);
								fix_q <= 2'd2;
								cnt_q <= cnt_q + CW'(1);
							end
						end
					end else if (!own_hit_q) begin
						stat_q <= wfsa_pkg::ST_ID;
					end else begin
						bst_q <= own_ent_q.start; bsz_q <= own_ent_q.len;
					end
				end
				wfsa_pkg::S_SHIFT: begin
					sh_ph_q <= ~sh_ph_q;
					if (sh_ph_q) begin
						if (sh_q != sh_end_q) begin
							sh_q <= sh_up_q ? sh_q - CW'(1) : sh_q + CW'(1);
						end else if (rm_q != '0) begin
							rm_q <= rm_q - CW'(1);
							sh_q <= (own_idx_q != '0 && !own_prev_q.used)
							        ? CW'(own_idx_q) : CW'(own_idx_q) + CW'(1);
							cnt_q <= cnt_q - CW'(1);
							sh_end_q <= cnt_q - CW'(2);
						end
					end
				end
				wfsa_pkg::S_FIX: begin
					fix_q <= fix_q - 2'd1;
					if (kind_q == wfsa_pkg::REQ_RELEASE) begin
						// close the gap left by merged entries, one at a time
						fix_q <= 2'd0;
						if (merges != 2'd0) begin
							rm_q <= CW'(merges) - CW'(1);
							sh_up_q <= 1'b0; sh_ph_q <= 1'b0;
							sh_q <= (own_idx_q != '0 && !own_prev_q.used)
							        ? CW'(own_idx_q) : CW'(own_idx_q) + CW'(1);
							sh_end_q <= cnt_q - CW'(2);
							cnt_q <= cnt_q - CW'(1);
						end
					end
				end
				wfsa_pkg::S_RESP: begin
					if (!mval_q || m_tready) mval_q <= 1'b1;
				end
				default: ;
			endcase
			// release with merges may continue into shift after fix
			if (st_q == wfsa_pkg::S_FIX && kind_q == wfsa_pkg::REQ_RELEASE
			    && merges != 2'd0 && !(cfg_valid && cfg_ready)) begin
				// shift only if there are entries above the merged run to move down
				if (CW'(own_idx_q)
				    + ((own_next_v_q && !own_next_q.used) ? CW'(2) : CW'(1)) < cnt_q)
					st_q <= wfsa_pkg::S_SHIFT;
				else begin
					cnt_q <= cnt_q - CW'(merges);
					rm_q <= '0;
				end
			end
			if (st_q == wfsa_pkg::S_SHIFT && sh_ph_q && sh_q == sh_end_q && rm_q == '0
			    && !sh_up_q) st_q <= wfsa_pkg::S_RESP;
		end
	end

	assign cfg_ready = (st_q == wfsa_pkg::S_IDLE);
	// hold off the next request while a response word waits
	assign s_tready  = (st_q == wfsa_pkg::S_IDLE) && !cfg_valid && !mval_q;
	assign m_tvalid  = mval_q;
	assign m_tdata   = {1'b0, bsz_q, bst_q, stat_q};

endmodule

// File: src/wfsa_check.sv
// ---------------------------------------------------------------------------
// wfsa_check: port-level checks of the worst-fit segment allocator
// Watches handshakes and response payload consistency.
// ---------------------------------------------------------------------------
module wfsa_check (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	// failures carry no range
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != 2'd0 |-> m_tdata[22:2] == '0)
		else $error("failed response with nonzero range");

	// ok responses carry a nonzero size
	a_ok_size: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == 2'd0 |-> m_tdata[22:12] != '0)
		else $error("ok response with zero size");

	// one request at a time: no accept while a response waits
	a_serial: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("request accepted while response pending");

	// stalled response holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("response dropped under stall");

endmodule

bind worst_fit_segment_allocator wfsa_check u_wfsa_check (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
